// File: hw/rtl/flcs_pkg.sv
// ----------------------------------------------------------------------------
// flcs_pkg
// Shared types and constants for the frame-linked call stack.
// ----------------------------------------------------------------------------
`default_nettype none

package flcs_pkg;

  // fixed field widths of the stream payloads
  localparam int DATA_W      = 32;
  localparam int MODE_W      = 3;
  localparam int DEPTH_W     = 8;
  localparam int ITEMS_W     = 8;
  localparam int ERR_W       = 2;
  localparam int ITEMS_MAX   = 255;
  localparam int IN_TDATA_W  = 72;  // value, return_address, depth_index
  localparam int OUT_TDATA_W = 40;  // read_value, frame_items

  // operation codes carried on in_tuser
  localparam logic [MODE_W-1:0] MODE_PUSH       = 3'd0;
  localparam logic [MODE_W-1:0] MODE_POP        = 3'd1;
  localparam logic [MODE_W-1:0] MODE_PEEK       = 3'd2;
  localparam logic [MODE_W-1:0] MODE_PUSH_FRAME = 3'd3;
  localparam logic [MODE_W-1:0] MODE_POP_FRAME  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_COUNT      = 3'd5;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK        = 2'd0,
    ERR_OVERFLOW  = 2'd1,
    ERR_UNDERFLOW = 2'd2,
    ERR_NO_FRAME  = 2'd3
  } flcs_err_t;

  // memory port operations: address and write data are picked by the datapath
  typedef enum logic [3:0] {
    MEM_IDLE    = 4'd0,
    MEM_WR_PUSH = 4'd1,   // top+1 <- value
    MEM_RD_TOP  = 4'd2,   // read top
    MEM_RD_PEEK = 4'd3,   // read top-depth
    MEM_WR_ZERO = 4'd4,   // top <- 0
    MEM_WR_RET  = 4'd5,   // top+1 <- return address
    MEM_WR_LINK = 4'd6,   // top+2 <- frame link
    MEM_WR_OLD  = 4'd7,   // top+3 <- held old top
    MEM_RD_LINK = 4'd8,   // read saved link
    MEM_RD_RET  = 4'd9,   // read saved return address
    MEM_WR_RES  = 4'd10   // reserved slot <- read word
  } flcs_mem_op_t;

  typedef enum logic [2:0] {
    TOP_HOLD     = 3'd0,
    TOP_INC      = 3'd1,
    TOP_DEC      = 3'd2,
    TOP_ADD3     = 3'd3,
    TOP_RESERVED = 3'd4
  } flcs_top_op_t;

  typedef enum logic [1:0] {
    LINK_HOLD    = 2'd0,
    LINK_PUSH    = 2'd1,
    LINK_RESTORE = 2'd2
  } flcs_link_op_t;

  typedef struct packed {
    logic          load_item;
    logic          clr_rd;
    flcs_mem_op_t  mem_op;
    logic          cap_rd;
    logic          cap_hold;
    flcs_top_op_t  top_op;
    flcs_link_op_t link_op;
    logic          load_result;
    logic          sel_items;
    flcs_err_t     err;
  } flcs_cmd_t;

  typedef struct packed {
    logic push_ok;
    logic pop_ok;
    logic peek_ok;
    logic frame_ok;
    logic link_ok;
    logic out_free;
  } flcs_status_t;

endpackage

`default_nettype wire

// File: hw/rtl/flcs_ctrl.sv
// ----------------------------------------------------------------------------
// flcs_ctrl
// Sequencer: decodes the operation and steps the datapath through it.
// ----------------------------------------------------------------------------
`default_nettype none

module flcs_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [flcs_pkg::MODE_W-1:0]   in_mode,
  input  flcs_pkg::flcs_status_t        status,
  output flcs_pkg::flcs_cmd_t           cmd
);

  import flcs_pkg::*;

  typedef enum logic [10:0] {
    ST_IDLE    = 11'b000_0000_0001,
    ST_DECODE  = 11'b000_0000_0010,
    ST_CAP_RD  = 11'b000_0000_0100,
    ST_PF_ZERO = 11'b000_0000_1000,
    ST_PF_RET  = 11'b000_0001_0000,
    ST_PF_LINK = 11'b000_0010_0000,
    ST_PF_OLD  = 11'b000_0100_0000,
    ST_PO_RET  = 11'b000_1000_0000,
    ST_PO_TOP  = 11'b001_0000_0000,
    ST_PO_WR   = 11'b010_0000_0000,
    ST_FINISH  = 11'b100_0000_0000
  } flcs_state_t;

  flcs_state_t       state_r, state_nxt;
  logic [MODE_W-1:0] mode_r;
  flcs_err_t         err_r, err_nxt;

  assign in_tready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      err_r   <= ERR_OK;
    end else begin
      state_r <= state_nxt;
      err_r   <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      mode_r <= in_mode;
    end
  end

  always_comb begin
    state_nxt = state_r;
    err_nxt   = err_r;
    cmd       = '0;
    cmd.err   = err_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load_item = 1'b1;
          err_nxt       = ERR_OK;
          state_nxt     = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd.clr_rd = 1'b1;
        state_nxt  = ST_FINISH;
        case (mode_r)
          MODE_PUSH: begin
            if (status.push_ok) begin
              cmd.mem_op = MEM_WR_PUSH;
              cmd.top_op = TOP_INC;
            end else begin
              err_nxt = ERR_OVERFLOW;
            end
          end
          MODE_POP: begin
            if (status.pop_ok) begin
              cmd.mem_op = MEM_RD_TOP;
              state_nxt  = ST_CAP_RD;
            end else begin
              err_nxt = ERR_UNDERFLOW;
            end
          end
          MODE_PEEK: begin
            if (status.peek_ok) begin
              cmd.mem_op = MEM_RD_PEEK;
              state_nxt  = ST_CAP_RD;
            end else begin
              err_nxt = ERR_UNDERFLOW;
            end
          end
          MODE_PUSH_FRAME: begin
            if (status.frame_ok) begin
              cmd.mem_op = MEM_RD_TOP;
              state_nxt  = ST_PF_ZERO;
            end else begin
              err_nxt = ERR_OVERFLOW;
            end
          end
          MODE_POP_FRAME: begin
            if (status.link_ok) begin
              cmd.mem_op = MEM_RD_LINK;
              state_nxt  = ST_PO_RET;
            end else begin
              err_nxt = ERR_NO_FRAME;
            end
          end
          MODE_COUNT: begin
            state_nxt = ST_FINISH;
          end
          default: begin
            err_nxt = ERR_UNDERFLOW;
          end
        endcase
      end
      ST_CAP_RD: begin
        cmd.cap_rd = 1'b1;
        if (mode_r == MODE_POP) begin
          cmd.top_op = TOP_DEC;
        end
        state_nxt = ST_FINISH;
      end
      ST_PF_ZERO: begin
        cmd.cap_hold = 1'b1;
        cmd.mem_op   = MEM_WR_ZERO;
        state_nxt    = ST_PF_RET;
      end
      ST_PF_RET: begin
        cmd.mem_op = MEM_WR_RET;
        state_nxt  = ST_PF_LINK;
      end
      ST_PF_LINK: begin
        cmd.mem_op  = MEM_WR_LINK;
        cmd.link_op = LINK_PUSH;
        state_nxt   = ST_PF_OLD;
      end
      ST_PF_OLD: begin
        cmd.mem_op = MEM_WR_OLD;
        cmd.top_op = TOP_ADD3;
        state_nxt  = ST_FINISH;
      end
      ST_PO_RET: begin
        cmd.cap_hold = 1'b1;
        cmd.mem_op   = MEM_RD_RET;
        state_nxt    = ST_PO_TOP;
      end
      ST_PO_TOP: begin
        cmd.cap_rd = 1'b1;
        cmd.mem_op = MEM_RD_TOP;
        state_nxt  = ST_PO_WR;
      end
      ST_PO_WR: begin
        cmd.mem_op  = MEM_WR_RES;
        cmd.top_op  = TOP_RESERVED;
        cmd.link_op = LINK_RESTORE;
        state_nxt   = ST_FINISH;
      end
      ST_FINISH: begin
        cmd.sel_items = (mode_r == MODE_COUNT);
        if (status.out_free) begin
          cmd.load_result = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/flcs_dp.sv
// ----------------------------------------------------------------------------
// flcs_dp
// Stack memory, top and frame-link registers, checks and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module flcs_dp #(
  parameter int STACK_DEPTH = 256,
  parameter int WORD_BITS   = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  flcs_pkg::flcs_cmd_t           cmd,
  output flcs_pkg::flcs_status_t        status,
  input  logic [flcs_pkg::DATA_W-1:0]   in_value,
  input  logic [flcs_pkg::DATA_W-1:0]   in_return_address,
  input  logic [flcs_pkg::DEPTH_W-1:0]  in_depth_index,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [flcs_pkg::DATA_W-1:0]   out_read_value,
  output logic [flcs_pkg::ITEMS_W-1:0]  out_frame_items,
  output logic [flcs_pkg::ERR_W-1:0]    out_error_code
);

  import flcs_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = (WORD_BITS > AW + 1) ? WORD_BITS : AW + 1;  // link compare
  localparam int XW = (WORD_BITS > DATA_W) ? WORD_BITS : DATA_W;  // word <-> port
  localparam int PW = (AW > DEPTH_W) ? AW : DEPTH_W;              // peek compare
  localparam int QW = (AW > ITEMS_W) ? AW : ITEMS_W;              // item count

  logic [AW-1:0]        top_r, top_nxt;
  logic [AW-1:0]        link_r, link_nxt;
  logic [DATA_W-1:0]    value_r, ret_r;
  logic [DEPTH_W-1:0]   depth_r;
  logic [WORD_BITS-1:0] hold_r;
  logic [DATA_W-1:0]    rd_r;

  logic [WORD_BITS-1:0] mem [STACK_DEPTH];
  logic [WORD_BITS-1:0] rdata_r;
  logic                 rzero_r;
  logic [WORD_BITS-1:0] rword;

  logic                 mem_en, mem_we;
  logic [AW-1:0]        mem_addr;
  logic [WORD_BITS-1:0] mem_wdata;

  logic                 out_valid_r;
  logic [DATA_W-1:0]    out_rd_r;
  logic [ITEMS_W-1:0]   out_items_r;
  logic [ERR_W-1:0]     out_err_r;

  logic [XW-1:0]        value_x, ret_x, rword_x;
  logic [CW-1:0]        link_c, hold_c;
  logic                 hold_link_ok;
  logic [QW-1:0]        top_q, link_q, cnt;
  logic [ITEMS_W-1:0]   items;

  // slot 0 is never written and always reads as zero
  assign rword   = rzero_r ? '0 : rdata_r;
  assign value_x = XW'(value_r);
  assign ret_x   = XW'(ret_r);
  assign rword_x = XW'(rword);
  assign link_c  = CW'(link_r);
  assign hold_c  = CW'(hold_r);

  assign hold_link_ok = (hold_c >= CW'(2)) && (hold_c < CW'(STACK_DEPTH));

  // status towards the sequencer
  always_comb begin
    status.push_ok  = (AW+1)'(top_r) < (AW+1)'(STACK_DEPTH - 1);
    status.pop_ok   = (top_r != '0);
    status.peek_ok  = PW'(depth_r) < PW'(top_r);
    status.frame_ok = ((AW+2)'(top_r) + (AW+2)'(3)) <= (AW+2)'(STACK_DEPTH - 1);
    status.link_ok  = (link_r >= AW'(2));
    status.out_free = !out_valid_r || out_ready;
  end

  // frame item count, saturated
  always_comb begin
    top_q  = QW'(top_r);
    link_q = QW'(link_r);
    if (link_r == '0) begin
      cnt = top_q;
    end else if (top_r > link_r) begin
      cnt = top_q - link_q;
    end else begin
      cnt = '0;
    end
    items = (cnt > QW'(ITEMS_MAX)) ? {ITEMS_W{1'b1}} : cnt[ITEMS_W-1:0];
  end

  // memory port steering
  always_comb begin
    mem_en    = 1'b1;
    mem_we    = 1'b1;
    mem_addr  = top_r;
    mem_wdata = '0;
    case (cmd.mem_op)
      MEM_WR_PUSH: begin
        mem_addr  = top_r + AW'(1);
        mem_wdata = value_x[WORD_BITS-1:0];
      end
      MEM_RD_TOP: begin
        mem_we = 1'b0;
      end
      MEM_RD_PEEK: begin
        mem_we   = 1'b0;
        mem_addr = top_r - AW'(depth_r);
      end
      MEM_WR_ZERO: begin
        mem_wdata = '0;
      end
      MEM_WR_RET: begin
        mem_addr  = top_r + AW'(1);
        mem_wdata = ret_x[WORD_BITS-1:0];
      end
      MEM_WR_LINK: begin
        mem_addr  = top_r + AW'(2);
        mem_wdata = link_c[WORD_BITS-1:0];
      end
      MEM_WR_OLD: begin
        mem_addr  = top_r + AW'(3);
        mem_wdata = hold_r;
      end
      MEM_RD_LINK: begin
        mem_we   = 1'b0;
        mem_addr = link_r;
      end
      MEM_RD_RET: begin
        mem_we   = 1'b0;
        mem_addr = link_r - AW'(1);
      end
      MEM_WR_RES: begin
        mem_addr  = link_r - AW'(2);
        mem_wdata = rword;
      end
      default: begin
        mem_en = 1'b0;
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_en) begin
      if (mem_we) begin
        if (mem_addr != '0) begin
          mem[mem_addr] <= mem_wdata;
        end
      end else begin
        rdata_r <= mem[mem_addr];
        rzero_r <= (mem_addr == '0);
      end
    end
  end

  // top and link updates
  always_comb begin
    case (cmd.top_op)
      TOP_INC:      top_nxt = top_r + AW'(1);
      TOP_DEC:      top_nxt = top_r - AW'(1);
      TOP_ADD3:     top_nxt = top_r + AW'(3);
      TOP_RESERVED: top_nxt = link_r - AW'(2);
      default:      top_nxt = top_r;
    endcase
    case (cmd.link_op)
      LINK_PUSH:    link_nxt = top_r + AW'(2);
      LINK_RESTORE: link_nxt = hold_link_ok ? hold_c[AW-1:0] : '0;
      default:      link_nxt = link_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r       <= '0;
      link_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      top_r  <= top_nxt;
      link_r <= link_nxt;
      if (cmd.load_result) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // item, capture and result payload
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      value_r <= in_value;
      ret_r   <= in_return_address;
      depth_r <= in_depth_index;
    end
    if (cmd.cap_hold) begin
      hold_r <= rword;
    end
    if (cmd.clr_rd) begin
      rd_r <= '0;
    end else if (cmd.cap_rd) begin
      rd_r <= rword_x[DATA_W-1:0];
    end
    if (cmd.load_result) begin
      out_rd_r    <= rd_r;
      out_items_r <= cmd.sel_items ? items : '0;
      out_err_r   <= cmd.err;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_read_value  = out_rd_r;
  assign out_frame_items = out_items_r;
  assign out_error_code  = out_err_r;

endmodule

`default_nettype wire

// File: hw/rtl/frame_linked_call_stack_core.sv
// ----------------------------------------------------------------------------
// frame_linked_call_stack_core
// Word stack with a linked frame pointer in one single-ported memory.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | tdata (low bit up)                        | tuser
//  --------+-----------+-------------------------------------------+-----------
//  in_     | slave     | value 32, return_address 32, depth_idx 8  | mode 3
//  out_    | master    | read_value 32, frame_items 8              | error 2
//
//  One beat in, one beat out. Items are handled one at a time: the next beat
//  is taken once the sequencer is idle again. Push, frame count and any error
//  take the fewest steps, then pop and peek, then pop frame, and push frame the most, as set
//  by the single memory port (one access per cycle, read data registered).
//  The result register lets the next beat in while a result waits; an item
//  only holds at its final step while the previous result is still unsent.
//  rst_n is synchronous: top and frame link clear to empty, no memory sweep.
//
`default_nettype none

module frame_linked_call_stack_core #(
  parameter int STACK_DEPTH = 256,
  parameter int WORD_BITS   = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [flcs_pkg::IN_TDATA_W-1:0]    in_tdata,   // value, return_address, depth_index
  input  logic [flcs_pkg::MODE_W-1:0]        in_tuser,   // mode
  // result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [flcs_pkg::OUT_TDATA_W-1:0]   out_tdata,  // read_value, frame_items
  output logic [flcs_pkg::ERR_W-1:0]         out_tuser   // error_code
);

  import flcs_pkg::*;

  flcs_cmd_t          cmd;
  flcs_status_t       status;
  logic [DATA_W-1:0]  read_value;
  logic [ITEMS_W-1:0] frame_items;

  // sequencer: one state per memory access
  flcs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_mode   (in_tuser),
    .status    (status),
    .cmd       (cmd)
  );

  // storage, pointer arithmetic and result register
  flcs_dp #(
    .STACK_DEPTH (STACK_DEPTH),
    .WORD_BITS   (WORD_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .in_value          (in_tdata[31:0]),
    .in_return_address (in_tdata[63:32]),
    .in_depth_index    (in_tdata[71:64]),
    .out_valid         (out_tvalid),
    .out_ready         (out_tready),
    .out_read_value    (read_value),
    .out_frame_items   (frame_items),
    .out_error_code    (out_tuser)
  );

  assign out_tdata = {frame_items, read_value};

endmodule

`default_nettype wire

// File: tb/flcs_scoreboard_pkg.sv
// ----------------------------------------------------------------------------
// flcs_scoreboard_pkg
// Predictor and result store for the frame-linked call stack testbench.
// ----------------------------------------------------------------------------
`default_nettype none

package flcs_scoreboard_pkg;

  import flcs_pkg::*;

  localparam int STACK_SLOTS = 256;

  typedef struct packed {
    logic [DATA_W-1:0]  read_value;
    logic [ITEMS_W-1:0] frame_items;
    flcs_err_t          err;
  } stack_result_t;

  class stack_scoreboard;
    logic [DATA_W-1:0] words [STACK_SLOTS];
    bit                written [STACK_SLOTS];
    int unsigned       top;
    int unsigned       link;
    stack_result_t     due [$];
    int unsigned       errors;
    int unsigned       checked;
    int unsigned       max_top;
    int unsigned       mode_hits [8];
    int unsigned       err_hits [4];

    function new();
      foreach (words[i]) begin
        words[i]   = '0;
        written[i] = (i == 0);
      end
      top     = 0;
      link    = 0;
      errors  = 0;
      checked = 0;
      max_top = 0;
      foreach (mode_hits[i]) mode_hits[i] = 0;
      foreach (err_hits[i]) err_hits[i] = 0;
    endfunction

    // slot 0 is the fixed zero bottom entry and never changes
    function void put(int unsigned slot, logic [DATA_W-1:0] word);
      if (slot != 0 && slot < STACK_SLOTS) begin
        words[slot]   = word;
        written[slot] = 1'b1;
      end
    endfunction

    // true when the operation touches only slots that hold a written word
    function bit reads_known(logic [MODE_W-1:0] mode, logic [DEPTH_W-1:0] depth);
      case (mode)
        MODE_POP:        return top == 0 || written[top];
        MODE_PEEK:       return depth >= top || written[top - depth];
        MODE_PUSH_FRAME: return top + 3 > STACK_SLOTS - 1 || written[top];
        MODE_POP_FRAME:  return link < 2 || link >= STACK_SLOTS ||
                                (written[link] && written[link - 1] && written[top]);
        default:         return 1'b1;
      endcase
    endfunction

    function void note_input(logic [MODE_W-1:0] mode, logic [DATA_W-1:0] value,
                             logic [DATA_W-1:0] ret, logic [DEPTH_W-1:0] depth);
      stack_result_t     r;
      logic [DATA_W-1:0] held;
      logic [DATA_W-1:0] saved;
      int unsigned       resv;
      int unsigned       count;
      r     = '0;
      r.err = ERR_OK;
      mode_hits[mode]++;
      case (mode)
        MODE_PUSH: begin
          if (top >= STACK_SLOTS - 1) begin
            r.err = ERR_OVERFLOW;
          end else begin
            top++;
            put(top, value);
          end
        end
        MODE_POP: begin
          if (top == 0) begin
            r.err = ERR_UNDERFLOW;
          end else begin
            r.read_value = words[top];
            top--;
          end
        end
        MODE_PEEK: begin
          if (depth >= top) r.err = ERR_UNDERFLOW;
          else r.read_value = words[top - depth];
        end
        MODE_PUSH_FRAME: begin
          if (top + 3 > STACK_SLOTS - 1) begin
            r.err = ERR_OVERFLOW;
          end else begin
            held = words[top];
            put(top, '0);
            put(top + 1, ret);
            put(top + 2, link);
            link = top + 2;
            put(top + 3, held);
            top += 3;
          end
        end
        MODE_POP_FRAME: begin
          if (link < 2 || link >= STACK_SLOTS) begin
            r.err = ERR_NO_FRAME;
          end else begin
            resv         = link - 2;
            saved        = words[link];
            r.read_value = words[link - 1];
            put(resv, words[top]);
            top  = resv;
            link = (saved >= 2 && saved < STACK_SLOTS) ? saved : 0;
          end
        end
        MODE_COUNT: begin
          if (link == 0) count = top;
          else if (top > link) count = top - link;
          else count = 0;
          r.frame_items = ITEMS_W'((count > ITEMS_MAX) ? ITEMS_MAX : count);
        end
        default: r.err = ERR_UNDERFLOW;
      endcase
      if (top > max_top) max_top = top;
      err_hits[r.err]++;
      due.push_back(r);
    endfunction

    function void check_result(logic [DATA_W-1:0] rd, logic [ITEMS_W-1:0] items,
                               logic [ERR_W-1:0] err);
      stack_result_t e;
      if (due.size() == 0) begin
        $error("unexpected result beat: read_value %h frame_items %0d error_code %0d",
               rd, items, err);
        errors++;
        return;
      end
      e = due.pop_front();
      checked++;
      if (rd !== e.read_value) begin
        $error("read_value: expected %h, got %h", e.read_value, rd);
        errors++;
      end
      if (items !== e.frame_items) begin
        $error("frame_items: expected %0d, got %0d", e.frame_items, items);
        errors++;
      end
      if (err !== e.err) begin
        $error("error_code: expected %0d, got %0d", e.err, err);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return due.size();
    endfunction
  endclass

endpackage

`default_nettype wire

// File: tb/tb_frame_linked_call_stack_core.sv
// ----------------------------------------------------------------------------
// tb_frame_linked_call_stack_core
// Stream-level check of the call stack core against a behavioural predictor.
// ----------------------------------------------------------------------------
//
// A short directed run walks the empty-stack errors, spare opcodes, nested
// frames, frame pops with the top below the link and a clobbered saved link.
// Four random phases follow with different idling on both sides; two of them
// fill the stack to the brim to hit overflow and the push-frame room limit.
// One phase holds the result side off for a long stretch while input keeps
// coming. Every result beat is compared field by field, in order.
//
`default_nettype none

module tb_frame_linked_call_stack_core;

  timeunit 1ns;
  timeprecision 1ps;

  import flcs_pkg::*;
  import flcs_scoreboard_pkg::*;

  // opcodes the core has no use for; both must come back as underflow
  localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd7;

  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned TIMEOUT_NS   = 3_000_000;

  logic                   clk;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;  // value, return_address, depth_index
  logic [MODE_W-1:0]      in_tuser   = '0;  // mode
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;        // read_value, frame_items
  logic [ERR_W-1:0]       out_tuser;        // error_code

  // idling knobs, percentages per cycle
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;

  // long hold-off handshake: main bumps the request count, the receiver
  // process serves it and counts the cycles itself
  int unsigned hold_requests = 0;
  int unsigned holds_served  = 0;
  int unsigned hold_left     = 0;

  stack_scoreboard sb;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  frame_linked_call_stack_core #(
    .STACK_DEPTH (STACK_SLOTS),
    .WORD_BITS   (DATA_W)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // --------------------------------------------------------------------------
  // Result side: random back-pressure, plus the long hold-off when asked
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (holds_served != hold_requests) begin
      out_tready   <= 1'b0;
      hold_left    <= HOLD_CYCLES;
      holds_served <= holds_served + 1;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // every accepted result beat goes straight to the checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tdata[DATA_W-1:0], out_tdata[DATA_W +: ITEMS_W], out_tuser);
  end

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------

  // Offer one beat, after a random number of idle cycles. The predictor is
  // updated at the accepting edge, so the next item is chosen from the
  // state the core will be in. Operations that would read a slot never
  // written are turned into a frame count.
  task automatic send_item(input logic [MODE_W-1:0] mode, input logic [DATA_W-1:0] value,
                           input logic [DATA_W-1:0] ret, input logic [DEPTH_W-1:0] depth);
    if (!sb.reads_known(mode, depth)) mode = MODE_COUNT;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {depth, ret, value};
    do @(posedge clk); while (!in_tready);
    sb.note_input(mode, value, ret, depth);
  endtask

  // sender pause: nothing offered until every expected result is back
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // words lean towards the extremes and towards small numbers, which look
  // like plausible links once they land in a saved-link slot
  function automatic logic [DATA_W-1:0] rand_word();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return DATA_W'($urandom_range(300));
      default: return $urandom;
    endcase
  endfunction

  task automatic random_item(input int unsigned push_w);
    logic [MODE_W-1:0]  mode;
    logic [DEPTH_W-1:0] depth;
    int unsigned        roll;
    roll = $urandom_range(99);
    if (roll < push_w) begin
      mode = MODE_PUSH;
    end else begin
      roll = $urandom_range(99);
      if (roll < 25) mode = MODE_POP;
      else if (roll < 45) mode = MODE_PEEK;
      else if (roll < 65) mode = MODE_PUSH_FRAME;
      else if (roll < 85) mode = MODE_POP_FRAME;
      else if (roll < 95) mode = MODE_COUNT;
      else mode = $urandom_range(1) ? MODE_SPARE_A : MODE_SPARE_B;
    end
    // mostly in range, the edge case top itself included
    if ($urandom_range(9) == 0) depth = DEPTH_W'($urandom_range(255));
    else depth = DEPTH_W'($urandom_range(sb.top, 0));
    send_item(mode, rand_word(), $urandom, depth);
  endtask

  // Push to a full stack, then work the edges: overflow, push frame with no
  // room, deepest peek and one past it, and push frame one short and just
  // fitting under the ceiling.
  task automatic fill_to_top();
    while (sb.top < STACK_SLOTS - 1)
      send_item(MODE_PUSH, rand_word(), $urandom, DEPTH_W'($urandom_range(255)));
    send_item(MODE_PUSH, rand_word(), $urandom, '0);
    send_item(MODE_PUSH_FRAME, '0, $urandom, '0);
    send_item(MODE_PEEK, '0, '0, DEPTH_W'(STACK_SLOTS - 2));
    send_item(MODE_PEEK, '0, '0, DEPTH_W'(STACK_SLOTS - 1));
    send_item(MODE_COUNT, '0, '0, '0);
    send_item(MODE_POP, '0, '0, '0);
    send_item(MODE_POP, '0, '0, '0);
    send_item(MODE_PUSH_FRAME, '0, $urandom, '0);
    send_item(MODE_POP, '0, '0, '0);
    send_item(MODE_PUSH_FRAME, '0, $urandom, '0);
    send_item(MODE_POP_FRAME, '0, '0, '0);
  endtask

  // One random phase. The push weight shifts every 60 items so the depth
  // wanders between empty and full. A squeeze phase asks for the long
  // receiver hold-off halfway through and keeps offering beats meanwhile.
  task automatic run_phase(input int unsigned idle, input int unsigned stall,
                           input int unsigned count, input bit fill, input bit squeeze);
    int unsigned push_w;
    send_idle_pct = idle;
    stall_pct     = stall;
    push_w        = 35;
    if (fill) fill_to_top();
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 60 == 0) begin
        case ($urandom_range(3))
          0:       push_w = 15;
          1:       push_w = 35;
          2:       push_w = 50;
          default: push_w = 70;
        endcase
      end
      if (squeeze && n == count / 2) hold_requests++;
      random_item(push_w);
    end
    wait_drained();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // empty stack: every read is an error, count is zero
    send_item(MODE_POP, '0, '0, '0);
    send_item(MODE_PEEK, '0, '0, '1);
    send_item(MODE_POP_FRAME, '0, '0, '0);
    send_item(MODE_COUNT, '0, '0, '0);
    send_item(MODE_SPARE_A, '1, '1, '1);
    send_item(MODE_SPARE_B, '0, '0, '0);
    // frame on an empty stack: bottom zero stands in as the old top
    send_item(MODE_PUSH_FRAME, '0, '1, '0);
    send_item(MODE_PUSH, '1, '0, '0);
    send_item(MODE_PUSH, '0, '1, '0);
    send_item(MODE_PEEK, '0, '0, 8'd0);
    send_item(MODE_PEEK, '0, '0, 8'd4);   // reaches the saved return address
    send_item(MODE_PEEK, '0, '0, 8'd5);   // depth equal to top: out of range
    send_item(MODE_COUNT, '0, '0, '0);
    // nested frame, popped straight away back to the outer one
    send_item(MODE_PUSH_FRAME, '0, '0, '0);
    send_item(MODE_POP_FRAME, '0, '0, '0);
    // drop the top to the frame link, count there, then go below it and pop the frame
    send_item(MODE_POP, '0, '0, '0);
    send_item(MODE_POP, '0, '0, '0);
    send_item(MODE_POP, '0, '0, '0);
    send_item(MODE_COUNT, '0, '0, '0);
    send_item(MODE_POP, '0, '0, '0);
    send_item(MODE_POP_FRAME, '0, '0, '0);
    // saved link overwritten with a slot past the end: frame cleared
    send_item(MODE_PUSH_FRAME, '0, 32'h1234_5678, '0);
    send_item(MODE_POP, '0, '0, '0);
    send_item(MODE_POP, '0, '0, '0);
    send_item(MODE_PUSH, 32'd300, '0, '0);
    send_item(MODE_POP_FRAME, '0, '0, '0);
    wait_drained();

    run_phase(0, 0, 300, 1'b1, 1'b0);    // back to back, no idling
    run_phase(62, 0, 420, 1'b0, 1'b0);   // sparse input
    run_phase(0, 62, 200, 1'b1, 1'b1);   // stalled output, long hold-off
    run_phase(24, 24, 600, 1'b0, 1'b0);  // both sides idling

    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run: %0d beats checked; push %0d pop %0d peek %0d, frame push %0d pop %0d",
             sb.checked, sb.mode_hits[MODE_PUSH], sb.mode_hits[MODE_POP],
             sb.mode_hits[MODE_PEEK], sb.mode_hits[MODE_PUSH_FRAME],
             sb.mode_hits[MODE_POP_FRAME]);
    $display("run: count %0d, spare %0d; overflow %0d underflow %0d no frame %0d; max top %0d",
             sb.mode_hits[MODE_COUNT], sb.mode_hits[MODE_SPARE_A] + sb.mode_hits[MODE_SPARE_B],
             sb.err_hits[ERR_OVERFLOW], sb.err_hits[ERR_UNDERFLOW],
             sb.err_hits[ERR_NO_FRAME], sb.max_top);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_frame_linked_call_stack_core: clean");
    end else begin
      $display("tb_frame_linked_call_stack_core: errors");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #(TIMEOUT_NS);
    $display("tb_frame_linked_call_stack_core: errors");
    $finish;
  end

endmodule

`default_nettype wire
